// ===== hw/rtl/circular_deque_top_defines.svh =====
// Assertion macros shared by the deque RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define CD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define CD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cd_pkg.sv =====
`default_nettype none

package cd_pkg;

  // Default number of words in the circular store.
  localparam int DefaultDepth = 16;

  // Fixed field widths.
  localparam int DataW = 32;
  localparam int OpW   = 2;
  localparam int StatW = 2;

  // Operation codes.
  localparam logic [OpW-1:0] OpAddFront = 2'd0;
  localparam logic [OpW-1:0] OpAddRear  = 2'd1;
  localparam logic [OpW-1:0] OpRemFront = 2'd2;
  localparam logic [OpW-1:0] OpRemRear  = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] StatDone  = 2'd0;
  localparam logic [StatW-1:0] StatFull  = 2'd1;
  localparam logic [StatW-1:0] StatEmpty = 2'd2;

  // Per-transaction result flags handed from the controller to the output stage.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic             take_read;
    logic             is_empty;
    logic             is_full;
  } cd_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cd_mem.sv =====
`default_nettype none

// Single-port-write, single-port-read word store with a registered read.
module cd_mem #(
  parameter int Depth = cd_pkg::DefaultDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(Depth)-1:0]       wr_addr_i,
  input  wire logic [cd_pkg::DataW-1:0]       wr_data_i,
  input  wire logic                           rd_en_i,
  input  wire logic [$clog2(Depth)-1:0]       rd_addr_i,
  output logic      [cd_pkg::DataW-1:0]       rd_data_o
);

  logic [cd_pkg::DataW-1:0] mem_q [Depth];
  logic [cd_pkg::DataW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cd_ctrl.sv =====
`default_nettype none

`include "circular_deque_top_defines.svh"

// Head, tail and count bookkeeping; issues the store accesses of each transaction.
module cd_ctrl #(
  parameter int Depth = cd_pkg::DefaultDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [cd_pkg::OpW-1:0]         op_i,
  output logic                                wr_en_o,
  output logic      [$clog2(Depth)-1:0]       wr_addr_o,
  output logic                                rd_en_o,
  output logic      [$clog2(Depth)-1:0]       rd_addr_o,
  output cd_pkg::cd_flags_t                   flags_o,
  output logic      [$clog2(Depth+1)-1:0]     occupancy_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty;
  logic [AW-1:0] head_prev, head_next, tail_prev, tail_next;
  logic [cd_pkg::StatW-1:0] status;
  logic          do_wr, do_rd;

  assign full  = (count_q == FullCnt);
  assign empty = (count_q == '0);

  // Wrapping neighbors of both ends.
  assign head_prev = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign head_next = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - AW'(1);
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);

  // Next state and store accesses for the offered operation.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    status    = cd_pkg::StatDone;
    do_wr     = 1'b0;
    do_rd     = 1'b0;
    wr_addr_o = '0;
    rd_addr_o = head_q;
    case (op_i)
      cd_pkg::OpAddFront, cd_pkg::OpAddRear: begin
        if (full) begin
          status = cd_pkg::StatFull;
        end else begin
          do_wr   = 1'b1;
          count_d = count_q + CW'(1);
          if (empty) begin
            head_d    = '0;
            tail_d    = '0;
            wr_addr_o = '0;
          end else if (op_i == cd_pkg::OpAddFront) begin
            head_d    = head_prev;
            wr_addr_o = head_prev;
          end else begin
            tail_d    = tail_next;
            wr_addr_o = tail_next;
          end
        end
      end
      cd_pkg::OpRemFront, cd_pkg::OpRemRear: begin
        if (empty) begin
          status = cd_pkg::StatEmpty;
        end else begin
          do_rd   = 1'b1;
          count_d = count_q - CW'(1);
          if (op_i == cd_pkg::OpRemFront) begin
            rd_addr_o = head_q;
            head_d    = head_next;
          end else begin
            rd_addr_o = tail_q;
            tail_d    = tail_prev;
          end
          // The last word leaves: both ends return to entry zero.
          if (count_q == CW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_en_o = accept_i && do_wr;
  assign rd_en_o = accept_i && do_rd;

  assign flags_o.status    = status;
  assign flags_o.take_read = do_rd;
  assign flags_o.is_empty  = (count_d == '0);
  assign flags_o.is_full   = (count_d == FullCnt);
  assign occupancy_o       = count_d;

  // Pointer and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  `CD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FullCnt, "count exceeds depth")
  `CD_ASSERT_NOW(a_empty_ptrs, count_q == '0, (head_q == '0) && (tail_q == '0),
                 "pointers not parked while empty")
  `CD_ASSERT_NOW(a_single_ptrs, count_q == CW'(1), head_q == tail_q,
                 "head and tail differ with one word stored")
  `CD_ASSERT_NXT(a_reject_hold, accept_i && (status != cd_pkg::StatDone),
                 (count_q == $past(count_q)) && (head_q == $past(head_q)),
                 "rejected transaction changed state")

endmodule

`default_nettype wire

// ===== hw/rtl/circular_deque_top.sv =====
// Each result passes through the pending stage and then the result register before it is
// offered on the result stream.
// Throughput: one transaction per cycle while the result stream is not stalled; the store
// read of a remove is registered in the memory, and the result stage keeps the pipe moving.
// Reset (rst_ni low, asynchronous): the queue is empty, both ends sit at entry zero,
// no result is pending. Store contents are not cleared and need no clearing pass.
`default_nettype none

`include "circular_deque_top_defines.svh"

module circular_deque_top #(
  parameter int DEPTH = cd_pkg::DefaultDepth
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [cd_pkg::DataW-1:0]            s_axis_tdata,  // [31:0] push_value
  input  wire logic [cd_pkg::OpW-1:0]              s_axis_tuser,  // [1:0] operation
  // Result stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // removed_value, then occupancy, then zero fill to whole bytes
  output logic [((cd_pkg::DataW+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // status (2 bits), is_empty, is_full
  output logic [cd_pkg::StatW+1:0]                 m_axis_tuser
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OutDW = ((cd_pkg::DataW + CW + 7) / 8) * 8;

  logic                     accept;
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [cd_pkg::DataW-1:0] rd_data;
  cd_pkg::cd_flags_t        flags;
  logic [CW-1:0]            occ;

  logic                     pend_q;
  cd_pkg::cd_flags_t        pend_flags_q;
  logic [CW-1:0]            pend_occ_q;
  logic                     out_valid_q;
  cd_pkg::cd_flags_t        out_flags_q;
  logic [CW-1:0]            out_occ_q;
  logic [cd_pkg::DataW-1:0] out_removed_q;
  logic                     out_free, pend_move;

  // Handshake: the pending stage drains whenever the result register can take it.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign pend_move     = pend_q && out_free;
  assign s_axis_tready = !pend_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cd_ctrl #(
    .Depth (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (s_axis_tuser),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .flags_o     (flags),
    .occupancy_o (occ)
  );

  cd_mem #(
    .Depth (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Pending stage: holds a result while the registered store read completes and until the result register takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept) begin
      pend_q <= 1'b1;
    end else if (pend_move) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_flags_q <= flags;
      pend_occ_q   <= occ;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_flags_q   <= pend_flags_q;
      out_occ_q     <= pend_occ_q;
      out_removed_q <= pend_flags_q.take_read ? rd_data : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDW'({out_occ_q, out_removed_q});
  assign m_axis_tuser  = {out_flags_q.is_full, out_flags_q.is_empty, out_flags_q.status};

  `CD_ASSERT_NXT(a_pend_hold, pend_q && !out_free, pend_q && $stable(pend_occ_q),
                 "pending result lost while output stalled")
  `CD_ASSERT_NXT(a_pend_load, pend_move, out_valid_q && (out_occ_q == $past(pend_occ_q)),
                 "pending result not moved to output")
  `CD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                 "result changed while the receiver stalled")

endmodule

`default_nettype wire

// ===== dv/circular_deque_top_tb.sv =====
`default_nettype none

module circular_deque_top_tb;

  localparam int Depth     = cd_pkg::DefaultDepth;
  localparam int OccW      = $clog2(Depth + 1);
  localparam int OutW      = ((cd_pkg::DataW + OccW + 7) / 8) * 8;
  localparam int RandItems = 825;
  localparam int CalmTail  = 150;
  localparam int HoldAt    = 300;
  localparam int HoldLen   = 60;
  localparam int Limit     = 100000;
  localparam int PrintCap  = 30;

  // One expected result of the deque.
  typedef struct {
    logic [cd_pkg::StatW-1:0] status;
    logic [cd_pkg::DataW-1:0] removed;
    logic [OccW-1:0]          occupancy;
    logic                     empty_flag;
    logic                     full_flag;
  } deque_result_t;

  // One stimulus row; typed rows carry their own expected result.
  typedef struct {
    logic [cd_pkg::OpW-1:0]   op;
    logic [cd_pkg::DataW-1:0] value;
    bit                       typed;
    logic [cd_pkg::StatW-1:0] status;
    logic [cd_pkg::DataW-1:0] removed;
    logic [OccW-1:0]          occupancy;
  } stim_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [cd_pkg::DataW-1:0]  s_axis_tdata;
  logic [cd_pkg::OpW-1:0]    s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OutW-1:0]           m_axis_tdata;
  logic [cd_pkg::StatW+1:0]  m_axis_tuser;

  circular_deque_top #(
    .DEPTH(Depth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Directed operations: empty rejects, extremes through a single entry, fill to full.
  stim_row_t plan [25] = '{
    '{cd_pkg::OpRemFront, 32'h0000_0000, 1'b1, cd_pkg::StatEmpty, 32'h0000_0000, 5'd0},
    '{cd_pkg::OpRemRear,  32'hFFFF_FFFF, 1'b1, cd_pkg::StatEmpty, 32'h0000_0000, 5'd0},
    '{cd_pkg::OpAddRear,  32'h7FFF_FFFF, 1'b1, cd_pkg::StatDone,  32'h0000_0000, 5'd1},
    '{cd_pkg::OpRemFront, 32'h1234_5678, 1'b1, cd_pkg::StatDone,  32'h7FFF_FFFF, 5'd0},
    '{cd_pkg::OpAddFront, 32'h8000_0000, 1'b1, cd_pkg::StatDone,  32'h0000_0000, 5'd1},
    '{cd_pkg::OpRemRear,  32'h0000_0000, 1'b1, cd_pkg::StatDone,  32'h8000_0000, 5'd0},
    '{cd_pkg::OpAddFront, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h0000_0001, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h5555_5555, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'hAAAA_AAAA, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h0000_0010, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'h0000_0011, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h0000_0012, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'h0000_0013, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h0000_0014, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'h0000_0015, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h0000_0016, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'h0000_0017, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h0000_0018, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'h0000_0019, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddRear,  32'h0000_001A, 1'b0, '0, '0, '0},
    '{cd_pkg::OpAddFront, 32'hDEAD_BEEF, 1'b1, cd_pkg::StatFull,  32'h0000_0000, 5'd16},
    '{cd_pkg::OpRemFront, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{cd_pkg::OpRemRear,  32'h0000_0000, 1'b0, '0, '0, '0}
  };

  // Predictor state: its own copy of the ring and both ends.
  logic [cd_pkg::DataW-1:0] ring [Depth];
  int               front_pos;
  int               back_pos;
  int               fill;
  int               peak_fill;

  deque_result_t    pending_results [$];
  int               mismatches;
  int               ops_accepted;
  int               results_seen;
  int               full_rejects;
  int               empty_rejects;
  int               words_returned;
  int               cycles;
  bit               idle_on;
  bit               long_hold_done;

  // Applies one operation to the predictor state and returns its result.
  function automatic deque_result_t deque_apply(input logic [cd_pkg::OpW-1:0] op,
                                                input logic [cd_pkg::DataW-1:0] val);
    deque_result_t r;
    r.status  = cd_pkg::StatDone;
    r.removed = '0;
    if (op == cd_pkg::OpAddFront || op == cd_pkg::OpAddRear) begin
      if (fill >= Depth) begin
        r.status = cd_pkg::StatFull;
      end else begin
        if (fill == 0) begin
          front_pos = 0;
          back_pos  = 0;
          ring[0]   = val;
        end else if (op == cd_pkg::OpAddFront) begin
          front_pos       = (front_pos + Depth - 1) % Depth;
          ring[front_pos] = val;
        end else begin
          back_pos       = (back_pos + 1) % Depth;
          ring[back_pos] = val;
        end
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.status = cd_pkg::StatEmpty;
      end else begin
        if (op == cd_pkg::OpRemFront) begin
          r.removed = ring[front_pos];
          front_pos = (front_pos + 1) % Depth;
        end else begin
          r.removed = ring[back_pos];
          back_pos  = (back_pos + Depth - 1) % Depth;
        end
        fill--;
        // The ends return to entry zero once the queue drains.
        if (fill == 0) begin
          front_pos = 0;
          back_pos  = 0;
        end
      end
    end
    if (fill > peak_fill) begin
      peak_fill = fill;
    end
    r.occupancy  = OccW'(fill);
    r.empty_flag = (fill == 0);
    r.full_flag  = (fill == Depth);
    return r;
  endfunction

  // Prints one mismatch line (up to a cap) and counts every one.
  task automatic report_mismatch(input string what, input logic [cd_pkg::DataW-1:0] got,
                                 input logic [cd_pkg::DataW-1:0] want);
    if (mismatches < PrintCap) begin
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // Offers one operation, waits for its transaction and queues the expected result.
  task automatic issue(input stim_row_t row);
    deque_result_t exp_res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.op;
    s_axis_tdata  <= row.value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_res = deque_apply(row.op, row.value);
    if (row.typed) begin
      exp_res.status     = row.status;
      exp_res.removed    = row.removed;
      exp_res.occupancy  = row.occupancy;
      exp_res.empty_flag = (row.occupancy == 0);
      exp_res.full_flag  = (row.occupancy == Depth);
    end
    pending_results.push_back(exp_res);
    ops_accepted++;
    @(negedge clk_i);
  endtask

  // Clock generation.
  always #4 clk_i = ~clk_i;

  // Cycle watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Timeout after %0d cycles with %0d results pending.",
               cycles, pending_results.size());
      $display("circular_deque_top verification failed");
      $finish;
    end
  end

  // Result receiver: random stall bursts and one long hold-off to back up the input.
  initial begin : result_sink
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && ops_accepted >= HoldAt) begin
        m_axis_tready <= 1'b0;
        repeat (HoldLen) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Compares each result transaction with the oldest expected result.
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("arrived with nothing pending",
                        m_axis_tdata[cd_pkg::DataW-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[cd_pkg::StatW-1:0] !== want.status)
          report_mismatch("status", m_axis_tuser[cd_pkg::StatW-1:0], want.status);
        if (m_axis_tdata[cd_pkg::DataW-1:0] !== want.removed)
          report_mismatch("removed_value", m_axis_tdata[cd_pkg::DataW-1:0], want.removed);
        if (m_axis_tdata[cd_pkg::DataW +: OccW] !== want.occupancy)
          report_mismatch("occupancy", m_axis_tdata[cd_pkg::DataW +: OccW], want.occupancy);
        if (m_axis_tuser[cd_pkg::StatW] !== want.empty_flag)
          report_mismatch("is_empty", m_axis_tuser[cd_pkg::StatW], want.empty_flag);
        if (m_axis_tuser[cd_pkg::StatW+1] !== want.full_flag)
          report_mismatch("is_full", m_axis_tuser[cd_pkg::StatW+1], want.full_flag);
        if (want.status == cd_pkg::StatFull) full_rejects++;
        if (want.status == cd_pkg::StatEmpty) empty_rejects++;
        if (want.status == cd_pkg::StatDone && (m_axis_tdata[cd_pkg::DataW-1:0] !== 'x)
            && want.removed !== '0) words_returned++;
      end
      results_seen++;
    end
  end

  // Main sequence: reset, directed table, biased random traffic, drain.
  initial begin : stimulus
    stim_row_t row;
    int        add_pct;
    int        pick;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = cd_pkg::OpAddFront;
    front_pos      = 0;
    back_pos       = 0;
    fill           = 0;
    peak_fill      = 0;
    mismatches     = 0;
    ops_accepted   = 0;
    results_seen   = 0;
    full_rejects   = 0;
    empty_rejects  = 0;
    words_returned = 0;
    cycles         = 0;
    idle_on        = 1'b1;
    long_hold_done = 1'b0;
    add_pct        = 50;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (plan[i]) begin
      issue(plan[i]);
    end

    // Random traffic in segments that lean toward filling, churning or draining.
    for (int n = 0; n < RandItems; n++) begin
      if (n % 30 == 0) begin
        pick    = $urandom_range(0, 2);
        add_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
      end
      if (n == RandItems - CalmTail) begin
        idle_on = 1'b0;
      end
      row.typed     = 1'b0;
      row.status    = '0;
      row.removed   = '0;
      row.occupancy = '0;
      if ($urandom_range(0, 99) < add_pct) begin
        row.op = $urandom_range(0, 1) ? cd_pkg::OpAddRear : cd_pkg::OpAddFront;
      end else begin
        row.op = $urandom_range(0, 1) ? cd_pkg::OpRemRear : cd_pkg::OpRemFront;
      end
      case ($urandom_range(0, 9))
        0: row.value = 32'h7FFF_FFFF;
        1: row.value = 32'h8000_0000;
        2: row.value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        default: row.value = $urandom;
      endcase
      issue(row);
    end
    s_axis_tvalid <= 1'b0;

    // Let every outstanding result come back, then idle before the summary.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d operations: %0d removes returned data, %0d adds refused at full,",
             ops_accepted, words_returned, full_rejects);
    $display("%0d removes refused at empty, peak occupancy %0d of %0d, one %0d-cycle output stall.",
             empty_rejects, peak_fill, Depth, HoldLen);
    if (mismatches == 0) begin
      $display("circular_deque_top verification clean");
    end else begin
      $display("circular_deque_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
